### sv/tli_pkg.sv
package tli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int STATUS_W    = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BELOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE  = 2'd2;

    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic signed [DATA_W-1:0]   q16_t;
    typedef logic [STATUS_W-1:0]        status_t;

endpackage

### sv/tli_in_if.sv
interface tli_in_if
    import tli_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    addr_t entry_index;
    q16_t  x_value;
    q16_t  y_value;

    modport source (output valid, output operation, output entry_index,
                    output x_value, output y_value, input ready);
    modport sink   (input valid, input operation, input entry_index,
                    input x_value, input y_value, output ready);
endinterface

### sv/tli_out_if.sv
interface tli_out_if
    import tli_pkg::*;
();
    logic    valid;
    logic    ready;
    q16_t    y_result;
    status_t range_status;

    modport source (output valid, output y_result, output range_status, input ready);
    modport sink   (input valid, input y_result, input range_status, output ready);
endinterface

### sv/table_linear_interpolator.sv
// Channel   Dir  Handshake           Payload
// in_ch     in   valid/ready         operation, entry_index, x_value, y_value
// out_ch    out  valid/ready         y_result, range_status
// cfg       in   cfg_we (no stall)   cfg_data -> point_count
//
// Writes can follow back to back.
// A lookup reads the first entry and, unless the query lies below the table or
// there is one point, the last entry; when interpolating it adds a linear scan
// of the table (one memory read per cycle), one 32x32 multiply, a rounding add
// and a 32-step serial divide.
// in_ch.ready is low while a lookup is in progress. A finished result waits
// in the output register; the next result stalls only if it is still held.
// rst_n clears control state and sets point_count to 1; table contents are
// undefined until written.
module table_linear_interpolator
    import tli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tli_in_if.sink             in_ch,
    tli_out_if.source          out_ch,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_RND,
        S_DIV,
        S_FIN,
        S_DONE
    } state_t;

    localparam int CNT_W = $clog2(DATA_W);

    q16_t x_mem [TABLE_DEPTH];
    q16_t y_mem [TABLE_DEPTH];
    q16_t x_rd_reg;
    q16_t y_rd_reg;
    addr_t rd_addr;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   point_count_reg;
    addr_t                last_idx_reg, last_idx_next;
    addr_t                scan_idx_reg, scan_idx_next;
    q16_t                 q_reg, q_next;
    q16_t                 lo_x_reg, lo_x_next;
    q16_t                 lo_y_reg, lo_y_next;
    q16_t                 last_y_reg, last_y_next;
    logic [DATA_W-1:0]    dx_reg, dx_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic [DATA_W-1:0]    dy_reg, dy_next;
    logic                 neg_reg, neg_next;
    logic [2*DATA_W-1:0]  prod_reg, prod_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    q16_t                 res_y_reg, res_y_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    q16_t                 out_y_reg, out_y_next;
    status_t              out_status_reg, out_status_next;

    logic                 in_xfer;
    logic                 out_xfer;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      dx_wide;
    logic [DATA_W:0]      den_wide;
    logic [DATA_W:0]      dy_wide;
    logic [2*DATA_W-1:0]  rounded;

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign in_xfer             = in_ch.valid && in_ch.ready;
    assign out_xfer            = out_valid_reg && out_ch.ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.y_result     = out_y_reg;
    assign out_ch.range_status = out_status_reg;

    // table storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_ch.operation == OP_WRITE)
        begin
            x_mem[in_ch.entry_index] <= in_ch.x_value;
            y_mem[in_ch.entry_index] <= in_ch.y_value;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            S_FIRST: rd_addr = last_idx_reg;
            S_LAST:  rd_addr = addr_t'(1);
            S_SCAN:  rd_addr = scan_idx_reg + addr_t'(1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_data;
        end
    end

    assign dx_wide  = {q_reg[DATA_W-1], q_reg} - {lo_x_reg[DATA_W-1], lo_x_reg};
    assign den_wide = {x_rd_reg[DATA_W-1], x_rd_reg} - {lo_x_reg[DATA_W-1], lo_x_reg};
    assign dy_wide  = (y_rd_reg < lo_y_reg)
                    ? {lo_y_reg[DATA_W-1], lo_y_reg} - {y_rd_reg[DATA_W-1], y_rd_reg}
                    : {y_rd_reg[DATA_W-1], y_rd_reg} - {lo_y_reg[DATA_W-1], lo_y_reg};
    assign rounded  = prod_reg + {{(DATA_W+1){1'b0}}, den_reg[DATA_W-1:1]};
    assign trial    = {rem_reg, quo_reg[DATA_W-1]};

    always_comb
    begin
        state_next      = state_reg;
        last_idx_next   = last_idx_reg;
        scan_idx_next   = scan_idx_reg;
        q_next          = q_reg;
        lo_x_next       = lo_x_reg;
        lo_y_next       = lo_y_reg;
        last_y_next     = last_y_reg;
        dx_next         = dx_reg;
        den_next        = den_reg;
        dy_next         = dy_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        res_y_next      = res_y_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_xfer;
        out_y_next      = out_y_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_ch.operation == OP_LOOKUP)
                begin
                    q_next = in_ch.x_value;
                    if (point_count_reg == '0)
                    begin
                        last_idx_next = '0;
                    end
                    else if (point_count_reg > COUNT_W'(TABLE_DEPTH))
                    begin
                        last_idx_next = addr_t'(TABLE_DEPTH - 1);
                    end
                    else
                    begin
                        last_idx_next = addr_t'(point_count_reg - COUNT_W'(1));
                    end
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                lo_x_next = x_rd_reg;
                lo_y_next = y_rd_reg;
                if (last_idx_reg == '0)
                begin
                    res_y_next      = y_rd_reg;
                    res_status_next = STATUS_INSIDE;
                    state_next      = S_DONE;
                end
                else if (q_reg < x_rd_reg)
                begin
                    res_y_next      = y_rd_reg;
                    res_status_next = STATUS_BELOW;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                last_y_next = y_rd_reg;
                if (q_reg > x_rd_reg)
                begin
                    res_y_next      = y_rd_reg;
                    res_status_next = STATUS_ABOVE;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_idx_next = addr_t'(1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (lo_x_reg <= q_reg && q_reg < x_rd_reg)
                begin
                    dx_next    = dx_wide[DATA_W-1:0];
                    den_next   = den_wide[DATA_W-1:0];
                    dy_next    = dy_wide[DATA_W-1:0];
                    neg_next   = (y_rd_reg < lo_y_reg);
                    state_next = S_MUL;
                end
                else
                begin
                    lo_x_next = x_rd_reg;
                    lo_y_next = y_rd_reg;
                    if (scan_idx_reg == last_idx_reg)
                    begin
                        res_y_next      = last_y_reg;
                        res_status_next = STATUS_INSIDE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + addr_t'(1);
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = {{DATA_W{1'b0}}, dx_reg} * {{DATA_W{1'b0}}, dy_reg};
                state_next = S_RND;
            end
            S_RND:
            begin
                // high word is already below den, so only 32 quotient bits remain
                rem_next   = rounded[2*DATA_W-1:DATA_W];
                quo_next   = rounded[DATA_W-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = DATA_W'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_y_next      = neg_reg ? q16_t'(lo_y_reg - $signed(quo_reg))
                                          : q16_t'(lo_y_reg + $signed(quo_reg));
                res_status_next = STATUS_INSIDE;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_y_next      = res_y_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_idx_reg   <= '0;
            scan_idx_reg   <= '0;
            q_reg          <= '0;
            lo_x_reg       <= '0;
            lo_y_reg       <= '0;
            last_y_reg     <= '0;
            dx_reg         <= '0;
            den_reg        <= '0;
            dy_reg         <= '0;
            neg_reg        <= 1'b0;
            prod_reg       <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            cnt_reg        <= '0;
            res_y_reg      <= '0;
            res_status_reg <= STATUS_INSIDE;
            out_valid_reg  <= 1'b0;
            out_y_reg      <= '0;
            out_status_reg <= STATUS_INSIDE;
        end
        else
        begin
            state_reg      <= state_next;
            last_idx_reg   <= last_idx_next;
            scan_idx_reg   <= scan_idx_next;
            q_reg          <= q_next;
            lo_x_reg       <= lo_x_next;
            lo_y_reg       <= lo_y_next;
            last_y_reg     <= last_y_next;
            dx_reg         <= dx_next;
            den_reg        <= den_next;
            dy_reg         <= dy_next;
            neg_reg        <= neg_next;
            prod_reg       <= prod_next;
            rem_reg        <= rem_next;
            quo_reg        <= quo_next;
            cnt_reg        <= cnt_next;
            res_y_reg      <= res_y_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_y_reg      <= out_y_next;
            out_status_reg <= out_status_next;
        end
    end

    a_lookup_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_ch.operation == OP_LOOKUP) |=> !in_ch.ready)
        else $error("input ready after lookup transfer");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg != '0 && scan_idx_reg <= last_idx_reg))
        else $error("scan index out of range");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || out_ch.ready)) |=>
        (out_valid_reg && out_y_reg == $past(res_y_reg)))
        else $error("result not loaded into output register");

endmodule

### tb/table_linear_interpolator_tb.sv
module table_linear_interpolator_tb
    import tli_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LATENCY_CYCLES = 320;
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     RANDOM_ITEMS   = 700;
    localparam int     REPORT_MAX     = 10;
    localparam q16_t   Q16_MIN        = 32'sh8000_0000;
    localparam q16_t   Q16_MAX        = 32'sh7FFF_FFFF;

    typedef struct {
        q16_t    y_result;
        status_t range_status;
    } lookup_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    tli_in_if  in_ch ();
    tli_out_if out_ch ();

    table_linear_interpolator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // breakpoint table as the block should hold it
    q16_t           bp_x [TABLE_DEPTH];
    q16_t           bp_y [TABLE_DEPTH];
    int unsigned    active_points;
    lookup_result_t pending_results [$];

    int src_idle_pct;
    int snk_idle_pct;
    int mismatches;
    int write_count;
    int lookup_count;
    int result_count;
    int setting_count;
    int idle_cycles;
    int random_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void predict_lookup(input q16_t query);
        int unsigned    n;
        longint         x0, x1, y0, y1, res;
        logic [63:0]    dx, den, dy, mag;
        logic           found;
        lookup_result_t r;
        n = active_points;
        if (n == 0)
            n = 1;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        r.range_status = STATUS_INSIDE;
        if (n == 1)
        begin
            res = bp_y[0];
        end
        else if (query < bp_x[0])
        begin
            res = bp_y[0];
            r.range_status = STATUS_BELOW;
        end
        else if (query > bp_x[n-1])
        begin
            res = bp_y[n-1];
            r.range_status = STATUS_ABOVE;
        end
        else
        begin
            res   = bp_y[n-1];
            found = 1'b0;
            for (int i = 0; i + 1 < n && !found; i++)
            begin
                if (bp_x[i] <= query && query < bp_x[i+1])
                begin
                    found = 1'b1;
                    x0  = bp_x[i];
                    x1  = bp_x[i+1];
                    y0  = bp_y[i];
                    y1  = bp_y[i+1];
                    dx  = query - x0;
                    den = x1 - x0;
                    dy  = (y1 < y0) ? y0 - y1 : y1 - y0;
                    // round to nearest, ties away from zero
                    mag = (dx * dy + den / 2) / den;
                    res = (y1 < y0) ? y0 - longint'(mag) : y0 + longint'(mag);
                end
            end
        end
        r.y_result = q16_t'(res);
        pending_results.push_back(r);
    endfunction

    task automatic send_item(input logic op, input addr_t idx, input q16_t xv, input q16_t yv);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.entry_index <= idx;
        in_ch.x_value     <= xv;
        in_ch.y_value     <= yv;
        do @(posedge clk); while (!in_ch.ready);
        if (op == OP_WRITE)
        begin
            bp_x[idx] = xv;
            bp_y[idx] = yv;
            write_count++;
        end
        else
        begin
            predict_lookup(xv);
            lookup_count++;
        end
    endtask

    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a trailing write may still be in flight
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic set_point_count(input int unsigned n);
        drain_block();
        cfg_we   <= 1'b1;
        cfg_data <= COUNT_W'(n);
        @(posedge clk);
        cfg_we        <= 1'b0;
        active_points = n;
        setting_count++;
    endtask

    task automatic test_single_point();
        send_item(OP_WRITE, 8'd0, -32'sh0001_0000, Q16_MIN);
        send_item(OP_LOOKUP, 8'hFF, Q16_MIN, Q16_MAX);
        send_item(OP_LOOKUP, 8'h00, Q16_MAX, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h5A, 32'sh0000_0000, 32'sh5555_5555);
    endtask

    task automatic test_clamp_and_exact();
        send_item(OP_WRITE, 8'd1, 32'sh0001_0000, Q16_MAX);
        send_item(OP_WRITE, 8'd2, 32'sh0003_0000, 32'sh0000_0000);
        send_item(OP_WRITE, 8'd3, 32'sh7FFF_FFFE, 32'sh1234_5678);
        set_point_count(4);
        send_item(OP_LOOKUP, 8'hA5, Q16_MIN, Q16_MIN);
        send_item(OP_LOOKUP, 8'h3C, Q16_MAX, Q16_MAX);
        send_item(OP_LOOKUP, 8'h00, -32'sh0001_0000, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'hFF, 32'sh7FFF_FFFE, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h81, 32'sh0003_0000, 32'sh0000_0000);
    endtask

    task automatic test_interpolate();
        send_item(OP_LOOKUP, 8'h12, 32'sh0000_0000, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h34, 32'sh0002_0000, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h56, 32'sh0001_0001, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h78, 32'sh7FFF_FFFD, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h9A, -32'sh0000_0001, 32'sh0000_0000);
    endtask

    task automatic test_unsorted_table();
        send_item(OP_WRITE, 8'd2, -32'sh0002_0000, 32'sh0000_0001);
        send_item(OP_LOOKUP, 8'h00, 32'sh0002_0000, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h00, -32'sh0001_8000, 32'sh0000_0000);
        send_item(OP_LOOKUP, 8'h00, 32'sh7FFF_FFFE, 32'sh0000_0000);
    endtask

    task automatic load_table(input int unsigned n);
        int     xs [$];
        longint v;
        logic   clustered;
        q16_t   yv;
        clustered = $urandom_range(0, 1);
        v = longint'(int'($urandom));
        for (int k = 0; k < n; k++)
        begin
            if (clustered)
            begin
                xs.push_back(int'(v));
                v += $urandom_range(0, 4096);
                if (v > longint'(Q16_MAX))
                    v = Q16_MAX;
            end
            else
            begin
                xs.push_back(int'($urandom));
            end
        end
        xs.sort();
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                yv = q16_t'($urandom_range(0, 131072) - 65536);
            else
                yv = q16_t'($urandom);
            send_item(OP_WRITE, addr_t'(k), q16_t'(xs[k]), yv);
            random_sent++;
        end
    endtask

    task automatic test_random_tables();
        int unsigned n, lookups, seg, i;
        longint      lo, hi, qv;
        seg = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (random_sent * 3 / RANDOM_ITEMS)
                0:       begin src_idle_pct = 8;  snk_idle_pct = 76; end
                1:       begin src_idle_pct = 76; snk_idle_pct = 8;  end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            case (seg)
                0:       n = 2;
                1:       n = TABLE_DEPTH;
                2:       n = 1;
                default: n = $urandom_range(3, 40);
            endcase
            load_table(n);
            set_point_count(n);
            lookups = (n == TABLE_DEPTH) ? 30 : $urandom_range(20, 45);
            repeat (lookups)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray write, may break the ordering
                    send_item(OP_WRITE, addr_t'($urandom), q16_t'($urandom), q16_t'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            lo = Q16_MIN;
                            hi = bp_x[0];
                            qv = (hi > lo) ? lo + longint'($urandom) % (hi - lo) : lo;
                        end
                        1:
                        begin
                            lo = bp_x[n-1];
                            hi = Q16_MAX;
                            qv = (hi > lo) ? hi - longint'($urandom) % (hi - lo) : hi;
                        end
                        2:       qv = bp_x[$urandom_range(0, n - 1)];
                        3:       qv = $urandom_range(0, 1) ? Q16_MAX : Q16_MIN;
                        4:       qv = int'($urandom);
                        default:
                        begin
                            if (n < 2)
                            begin
                                qv = int'($urandom);
                            end
                            else
                            begin
                                i  = $urandom_range(0, n - 2);
                                lo = bp_x[i];
                                hi = bp_x[i+1];
                                qv = (hi > lo) ? lo + longint'($urandom) % (hi - lo) : lo;
                            end
                        end
                    endcase
                    send_item(OP_LOOKUP, addr_t'($urandom), q16_t'(qv), q16_t'($urandom));
                end
                random_sent++;
            end
            seg++;
        end
    endtask

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transfer: y_result %h range_status %0d",
                             out_ch.y_result, out_ch.range_status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.y_result !== want.y_result ||
                    out_ch.range_status !== want.range_status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("lookup mismatch: expected y_result %h range_status %0d, %s",
                                 want.y_result, want.range_status,
                                 $sformatf("got y_result %h range_status %0d",
                                           out_ch.y_result, out_ch.range_status));
                end
            end
        end
        out_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= COUNT_W'(1);
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_WRITE;
        in_ch.entry_index <= '0;
        in_ch.x_value     <= '0;
        in_ch.y_value     <= '0;
        active_points = 1;
        src_idle_pct  = 8;
        snk_idle_pct  = 76;
        mismatches    = 0;
        write_count   = 0;
        lookup_count  = 0;
        result_count  = 0;
        setting_count = 0;
        idle_cycles   = 0;
        random_sent   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_point();
        test_clamp_and_exact();
        test_interpolate();
        test_unsorted_table();
        test_random_tables();

        drain_block();
        mismatches += pending_results.size();
        $display("Covered %0d breakpoint writes and %0d lookups (%0d results) over %0d settings",
                 write_count, lookup_count, result_count, setting_count);
        $display("of point_count up to %0d, with clamping, exact and unsorted breakpoints.",
                 TABLE_DEPTH);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
